// ===== design/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// pla_pkg: shared types and codes for the positional array list
// Operation codes, status codes, cell command struct and fixed field widths.
// ----------------------------------------------------------------------------
package pla_pkg;

	// operation codes carried in the operation field
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_LOCATE = 2'd3;

	// fixed payload widths
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned FOUND_W = 5;
	localparam int unsigned COUNT_W = 6;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== design/pla_in_if.sv =====
// ----------------------------------------------------------------------------
// pla_in_if: operation channel
// Valid/ready channel carrying one list operation per transfer.
// ----------------------------------------------------------------------------
interface pla_in_if import pla_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

// ===== design/pla_out_if.sv =====
// ----------------------------------------------------------------------------
// pla_out_if: result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface pla_out_if import pla_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [DATA_W-1:0] read_value;
	logic [FOUND_W-1:0]       found_position;
	logic [COUNT_W-1:0]       entry_count;
	logic                     is_empty;

	modport source (output valid, output status, output read_value,
		output found_position, output entry_count, output is_empty, input ready);
	modport sink (input valid, input status, input read_value,
		input found_position, input entry_count, input is_empty, output ready);
endinterface

// ===== design/pla_cell.sv =====
// ----------------------------------------------------------------------------
// pla_cell: one entry of the list chain
// Holds one entry, loads a new value or takes its left or right neighbor on
// insert and delete, and flags a match against the search value.
// ----------------------------------------------------------------------------
module pla_cell import pla_pkg::*; #(
	parameter int unsigned CW    = 9,
	parameter int unsigned INDEX = 0
) (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [CW-1:0]            pos,
	input  logic [CW-1:0]            count,
	input  logic signed [DATA_W-1:0] new_value,
	input  logic signed [DATA_W-1:0] left_entry,
	input  logic signed [DATA_W-1:0] right_entry,
	input  logic signed [DATA_W-1:0] search_value,
	output logic signed [DATA_W-1:0] entry,
	output logic                     match
);

	localparam logic [CW-1:0] IDX      = CW'(INDEX);
	localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

	logic signed [DATA_W-1:0] entry_q;

	// shift or load the held entry
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX == pos) begin
				entry_q <= new_value;
			end else if (IDX > pos && IDX <= count) begin
				entry_q <= left_entry;
			end
		end else if (cmd.del) begin
			if (IDX >= pos && IDX_NEXT < count) begin
				entry_q <= right_entry;
			end
		end
	end

	// compare against search value, live positions only
	assign match = (IDX < count) && (entry_q == search_value);
	assign entry = entry_q;

endmodule

// ===== design/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of signed entries in a chain of cells
// Insert, delete, get by position and locate by value, one result each.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | operation, position, value
//  out_ch   | out | status, read_value, found_position, entry_count, is_empty
//
// Insert, delete and get complete on the accepting edge: every cell shifts in
// parallel and the result is registered on that edge.
// Locate registers the per-cell match flags, then scans them one position a
// cycle up to the first match or the last entry; an empty list skips the scan.
// Reset clears the length, the scan state and the result valid; entries are
// undefined.
// A result waiting on out_ch blocks a new operation only if it is not taken.
// ----------------------------------------------------------------------------
module positional_array_list import pla_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input logic clk,
	input logic arst_n,
	pla_in_if.sink    in_ch,
	pla_out_if.source out_ch
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int unsigned RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                     state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAPACITY-1:0]      match_q;
	logic [IDX_W-1:0]         idx_q;

	logic                     out_valid_q;
	logic                     status_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [FOUND_W-1:0]       found_q;
	logic [COUNT_W-1:0]       entry_count_q;
	logic                     is_empty_q;

	logic                     accept;
	logic [CW-1:0]            pos_ext;
	logic [CW-1:0]            cnt_ext;
	logic                     ins_ok;
	logic                     pos_ok;
	logic                     del_ok;
	logic                     get_ok;
	logic [CNT_W-1:0]         count_next;
	logic signed [DATA_W-1:0] rd_sel;
	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]      match_w;
	logic                     scan_last;

	// handshake
	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;

	// position checks
	assign pos_ext = CW'(in_ch.position);
	assign cnt_ext = CW'(count_q);
	assign pos_ok  = pos_ext < cnt_ext;
	assign ins_ok  = (in_ch.operation == OP_INSERT) && (cnt_ext < CW'(CAPACITY))
		&& (pos_ext <= cnt_ext);
	assign del_ok  = (in_ch.operation == OP_DELETE) && pos_ok;
	assign get_ok  = (in_ch.operation == OP_GET) && pos_ok;

	assign cmd.ins = accept && ins_ok;
	assign cmd.del = accept && del_ok;

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// read select over reachable positions
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (pos_ext == CW'(i)) begin
				rd_sel = entry_w[i];
			end
		end
	end

	// chain of entry cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = entry_w[g+1];
		end
		pla_cell #(
			.CW    (CW),
			.INDEX (g)
		) u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.pos          (pos_ext),
			.count        (cnt_ext),
			.new_value    (in_ch.value),
			.left_entry   (left_w),
			.right_entry  (right_w),
			.search_value (in_ch.value),
			.entry        (entry_w[g]),
			.match        (match_w[g])
		);
	end

	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	// control: state, length, locate scan, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_next;
						if (in_ch.operation == OP_LOCATE && count_q != '0) begin
							state_q     <= ST_SCAN;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (out_ch.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (match_q[0] || scan_last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: match flags, scan index and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					match_q       <= match_w;
					idx_q         <= '0;
					status_q      <= (ins_ok || del_ok || get_ok) ? STATUS_OK : STATUS_ERR;
					read_value_q  <= (del_ok || get_ok) ? rd_sel : '0;
					found_q       <= '0;
					entry_count_q <= COUNT_W'(count_next);
					is_empty_q    <= (count_next == '0);
				end
			end
			ST_SCAN: begin
				if (match_q[0]) begin
					status_q <= STATUS_OK;
					found_q  <= FOUND_W'(idx_q);
				end else if (!scan_last) begin
					match_q <= match_q >> 1;
					idx_q   <= idx_q + IDX_W'(1);
				end
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

	// result channel
	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.read_value     = read_value_q;
	assign out_ch.found_position = found_q;
	assign out_ch.entry_count    = entry_count_q;
	assign out_ch.is_empty       = is_empty_q;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional array list
// Drives insert, delete, get and locate transfers with random gaps and result
// stalls, keeps a shadow copy of the list and compares every result field.
// ----------------------------------------------------------------------------
module tb_top import pla_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY   = 32;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned TAIL_WAIT  = 40;
	localparam int unsigned RAND_OPS   = 1330;

	// one result transfer, field by field
	typedef struct {
		logic                     status;
		logic signed [DATA_W-1:0] read_value;
		logic [FOUND_W-1:0]       found_position;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
	} list_result_t;

	// shadow copy of the list and the results it still owes
	class list_shadow;
		logic signed [DATA_W-1:0] cells[$];
		list_result_t             due_results[$];
		int unsigned              mismatches;
		int unsigned              results_seen;
		int unsigned              full_rejects;
		int unsigned              full_reached;
		int unsigned              op_total[4];
		int unsigned              op_fail[4];

		function int unsigned pending();
			return due_results.size();
		endfunction

		function int unsigned length();
			return cells.size();
		endfunction

		function void report_mismatch(string what);
			mismatches++;
			if (mismatches <= 30)
				$display("%0t mismatch: %s", $realtime, what);
		endfunction

		// work out the result of one accepted operation and update the list
		function void apply_op(logic [1:0] op, logic [POS_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
			list_result_t r;
			int unsigned  n;
			n = cells.size();
			r.status         = STATUS_ERR;
			r.read_value     = '0;
			r.found_position = '0;
			case (op)
				OP_INSERT: begin
					if (n >= CAPACITY)
						full_rejects++;
					if (n < CAPACITY && pos <= n) begin
						cells.insert(pos, val);
						r.status = STATUS_OK;
						if (cells.size() == CAPACITY)
							full_reached++;
					end
				end
				OP_DELETE: begin
					if (pos < n) begin
						r.read_value = cells[pos];
						cells.delete(pos);
						r.status = STATUS_OK;
					end
				end
				OP_GET: begin
					if (pos < n) begin
						r.read_value = cells[pos];
						r.status = STATUS_OK;
					end
				end
				default: begin
					for (int k = 0; k < n; k++) begin
						if (cells[k] == val) begin
							r.found_position = k[FOUND_W-1:0];
							r.status = STATUS_OK;
							break;
						end
					end
				end
			endcase
			r.entry_count = COUNT_W'(cells.size());
			r.is_empty    = (cells.size() == 0);
			op_total[op]++;
			if (r.status == STATUS_ERR)
				op_fail[op]++;
			due_results.push_back(r);
		endfunction

		// compare a result transfer against the oldest owed result
		function void check_result(list_result_t got);
			list_result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result transfer with no operation outstanding");
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0b want %0b",
					got.status, want.status));
			if (got.read_value !== want.read_value)
				report_mismatch($sformatf("read_value got %0d want %0d",
					got.read_value, want.read_value));
			if (got.found_position !== want.found_position)
				report_mismatch($sformatf("found_position got %0d want %0d",
					got.found_position, want.found_position));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count got %0d want %0d",
					got.entry_count, want.entry_count));
			if (got.is_empty !== want.is_empty)
				report_mismatch($sformatf("is_empty got %0b want %0b",
					got.is_empty, want.is_empty));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pla_in_if  in_ch ();
	pla_out_if out_ch ();

	positional_array_list #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	list_shadow  shadow = new();
	bit          send_burst;
	bit          take_burst = 1'b0;
	int unsigned idle_cycles = 0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls with stall-free stretches
	initial begin
		int unsigned stall;
		int unsigned stretch;
		out_ch.ready <= 1'b0;
		stall   = 0;
		stretch = 0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				take_burst = ($urandom_range(0, 3) == 0);
				stretch    = $urandom_range(50, 300);
			end else begin
				stretch--;
			end
			if (stall != 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (!take_burst && $urandom_range(0, 2) == 0) begin
				stall = idle_len();
				out_ch.ready <= (stall == 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.status         = out_ch.status;
				got.read_value     = out_ch.read_value;
				got.found_position = out_ch.found_position;
				got.entry_count    = out_ch.entry_count;
				got.is_empty       = out_ch.is_empty;
				shadow.check_result(got);
			end
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
				$display("[positional_array_list] ERROR");
				$finish;
			end
		end
	end

	// one operation transfer, with an optional gap in front
	task automatic send_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] val);
		int unsigned gap;
		gap = send_burst ? 0 : idle_len();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.position  <= pos;
		in_ch.value     <= val;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		shadow.apply_op(op, pos, val);
	endtask

	// hold off the sender until every owed result has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (shadow.pending() != 0);
	endtask

	// value mix: small pool for duplicates, extremes, copies, full random
	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $signed($urandom_range(0, 8)) - 4;
		if (r < 45)
			return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
		if (r < 60 && shadow.length() != 0)
			return shadow.cells[$urandom_range(0, shadow.length() - 1)];
		return $urandom();
	endfunction

	// random part: grow and shrink phases keep the list moving end to end
	task automatic run_random(input int unsigned n_ops);
		bit            growing;
		int unsigned   r;
		int unsigned   len;
		logic [1:0]    op;
		logic [POS_W-1:0] pos;
		growing = 1'b1;
		for (int unsigned i = 0; i < n_ops; i++) begin
			if (i % 120 == 0)
				send_burst = ($urandom_range(0, 2) == 0);
			if (i == n_ops / 3 || $urandom_range(0, 199) == 0)
				drain_results();
			len = shadow.length();
			if (len == CAPACITY && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (len == 0)
				growing = 1'b1;
			else if (i > 40 && $urandom_range(0, 59) == 0)
				growing = !growing;
			r = $urandom_range(0, 99);
			if (r < 45)
				op = growing ? OP_INSERT : OP_DELETE;
			else if (r < 60)
				op = growing ? OP_DELETE : OP_INSERT;
			else if (r < 80)
				op = OP_GET;
			else
				op = OP_LOCATE;
			// mostly legal positions, some past the end
			if ($urandom_range(0, 99) < 12 || len == 0)
				pos = POS_W'($urandom_range(0, CAPACITY));
			else if (op == OP_INSERT)
				pos = POS_W'($urandom_range(0, len));
			else
				pos = POS_W'($urandom_range(0, len - 1));
			send_op(op, pos, pick_value());
		end
	endtask

	// stimulus
	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.operation <= OP_INSERT;
		in_ch.position  <= '0;
		in_ch.value     <= '0;
		send_burst       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every read fails, insert past end fails
		send_op(OP_GET, 6'd0, 0);
		send_op(OP_DELETE, 6'd0, 0);
		send_op(OP_LOCATE, 6'd0, 0);
		send_op(OP_INSERT, 6'd1, 5);
		send_op(OP_GET, 6'd32, 0);
		// appends, front insert and extreme values
		send_op(OP_INSERT, 6'd0, 32'sh80000000);
		send_op(OP_INSERT, 6'd1, 32'sh7fffffff);
		send_op(OP_INSERT, 6'd0, -1);
		send_op(OP_INSERT, 6'd3, 0);
		send_op(OP_INSERT, 6'd5, 7);
		send_op(OP_INSERT, 6'd2, -1);
		send_op(OP_GET, 6'd0, 0);
		send_op(OP_GET, 6'd4, 0);
		send_op(OP_GET, 6'd5, 0);
		// locate: duplicates give the lowest position, then a miss
		send_op(OP_LOCATE, 6'd0, -1);
		send_op(OP_LOCATE, 6'd0, 0);
		send_op(OP_LOCATE, 6'd0, 32'sh7fffffff);
		send_op(OP_LOCATE, 6'd0, 12345);
		// delete middle, last and past the end, then empty it
		send_op(OP_DELETE, 6'd2, 0);
		send_op(OP_DELETE, 6'd3, 0);
		send_op(OP_DELETE, 6'd3, 0);
		send_op(OP_DELETE, 6'd0, 0);
		send_op(OP_DELETE, 6'd1, 0);
		send_op(OP_DELETE, 6'd0, 0);
		send_op(OP_LOCATE, 6'd0, 0);
		drain_results();

		// random part starts growing, so the list fills early on
		run_random(RAND_OPS);

		// let everything come back, then idle a little
		in_ch.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("covered %0d inserts, %0d deletes, %0d gets, %0d locates; %0d failed",
			shadow.op_total[OP_INSERT], shadow.op_total[OP_DELETE],
			shadow.op_total[OP_GET], shadow.op_total[OP_LOCATE],
			shadow.op_fail[OP_INSERT] + shadow.op_fail[OP_DELETE]
			+ shadow.op_fail[OP_GET] + shadow.op_fail[OP_LOCATE]);
		$display("list filled %0d times, %0d inserts rejected on a full list, %0d results",
			shadow.full_reached, shadow.full_rejects, shadow.results_seen);
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("[positional_array_list] OK");
		end else begin
			$display("[positional_array_list] ERROR");
		end
		$finish;
	end

endmodule

// ===== positional_array_list.f =====
design/pla_pkg.sv
design/pla_in_if.sv
design/pla_out_if.sv
design/pla_cell.sv
design/positional_array_list.sv
test/tb_top.sv
